FILE: rtl/lmc_pkg.sv
`default_nettype none

package lmc_pkg;

   // Duty and knob resolution
   localparam int DUTY_BITS  = 8;
   localparam int KNOB_BITS  = 12;
   localparam int KNOB_SHIFT = (KNOB_BITS >= DUTY_BITS) ? (KNOB_BITS - DUTY_BITS)
                                                         : (DUTY_BITS - KNOB_BITS);
   localparam int COLOUR_BITS = 3 * DUTY_BITS;

   // Configuration register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DEBOUNCE_TICKS = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SILENCE_TICKS  = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_MARKER   = 2'd2;

   localparam logic [7:0]  DEBOUNCE_RESET = 8'd50;
   localparam logic [15:0] SILENCE_RESET  = 16'd10000;
   localparam logic [7:0]  MARKER_RESET   = 8'hFF;

   localparam logic [7:0]  SINCE_PRESS_MAX = 8'hFF;
   localparam logic [15:0] SINCE_FRAME_MAX = 16'hFFFF;

   // Mode codes as reported on the result channel
   localparam logic [2:0] MODE_CODE_ON     = 3'd0;
   localparam logic [2:0] MODE_CODE_OFF    = 3'd1;
   localparam logic [2:0] MODE_CODE_KNOB   = 3'd2;
   localparam logic [2:0] MODE_CODE_ORANGE = 3'd3;
   localparam logic [2:0] MODE_CODE_VIOLET = 3'd4;

   typedef enum logic [4:0] {
      MODE_ON     = 5'b00001,
      MODE_OFF    = 5'b00010,
      MODE_KNOB   = 5'b00100,
      MODE_ORANGE = 5'b01000,
      MODE_VIOLET = 5'b10000
   } mode_type;

   typedef logic [DUTY_BITS-1:0]   duty_type;
   typedef logic [COLOUR_BITS-1:0] colour_type;

   // Input item, first field in the highest bits
   typedef struct packed {
      logic [7:0]  frame_blue;
      logic [7:0]  frame_green;
      logic [7:0]  frame_red;
      logic [7:0]  frame_first;
      logic        frame_valid;
      logic [11:0] knob_sample;
      logic        button_edge;
      logic        knob_switch_on;
      logic        head_switch_on;
   } item_type;

   // Result item, first field in the highest bits, zero padded to bytes
   typedef struct packed {
      logic [4:0] pad;
      logic [2:0] mode_now;
      logic [7:0] head_blue;
      logic [7:0] head_green;
      logic [7:0] head_red;
      logic [7:0] main_blue;
      logic [7:0] main_green;
      logic [7:0] main_red;
   } result_type;

   localparam int ITEM_BITS   = $bits(item_type);
   localparam int RESULT_BITS = $bits(result_type);
   localparam int MODE_LSB    = 48;
   localparam logic [2:0] MODE_CODE_MAX = MODE_CODE_VIOLET;

   typedef struct packed {
      logic [7:0]  debounce_ticks;
      logic [15:0] silence_ticks;
      logic [7:0]  start_marker;
   } cfg_type;

   function automatic colour_type rgb(input duty_type r, input duty_type g, input duty_type b);
      return {r, g, b};
   endfunction

   function automatic duty_type chan(input colour_type c, input int idx);
      return c[idx*DUTY_BITS +: DUTY_BITS];
   endfunction

   localparam colour_type ORANGE = rgb(DUTY_BITS'(8'h50), DUTY_BITS'(8'h80), DUTY_BITS'(8'h00));
   localparam colour_type VIOLET = rgb(DUTY_BITS'(8'h90), DUTY_BITS'(8'h10), DUTY_BITS'(8'hDD));

   function automatic duty_type knob_grey(input logic [KNOB_BITS-1:0] knob);
      duty_type grey;
      if (KNOB_BITS >= DUTY_BITS) begin
         grey = DUTY_BITS'(knob >> KNOB_SHIFT);
      end else begin
         grey = DUTY_BITS'(knob) << KNOB_SHIFT;
      end
      return grey;
   endfunction

   function automatic logic [2:0] mode_code(input mode_type m);
      logic [2:0] code;
      case (m)
         MODE_ON:     code = MODE_CODE_ON;
         MODE_OFF:    code = MODE_CODE_OFF;
         MODE_KNOB:   code = MODE_CODE_KNOB;
         MODE_ORANGE: code = MODE_CODE_ORANGE;
         MODE_VIOLET: code = MODE_CODE_VIOLET;
         default:     code = MODE_CODE_ON;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

FILE: rtl/lmc_csr.sv
`default_nettype none

module lmc_csr (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_wen,
   input  wire  [lmc_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  wire  [lmc_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   output lmc_pkg::cfg_type                      cfg
);

   lmc_pkg::cfg_type cfg_ff;
   lmc_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         case (csr_index)
            lmc_pkg::CSR_DEBOUNCE_TICKS: cfg_in.debounce_ticks = csr_wdata[7:0];
            lmc_pkg::CSR_SILENCE_TICKS:  cfg_in.silence_ticks  = csr_wdata[15:0];
            lmc_pkg::CSR_START_MARKER:   cfg_in.start_marker   = csr_wdata[7:0];
            default:                     cfg_in = cfg_ff;   // drop writes to unused index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks <= lmc_pkg::DEBOUNCE_RESET;
         cfg_ff.silence_ticks  <= lmc_pkg::SILENCE_RESET;
         cfg_ff.start_marker   <= lmc_pkg::MARKER_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

FILE: rtl/lmc_core.sv
`default_nettype none

module lmc_core (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  step,
   input  lmc_pkg::item_type    item,
   input  lmc_pkg::cfg_type     cfg,
   output lmc_pkg::result_type  result
);

   lmc_pkg::mode_type   mode_ff, mode_in;
   logic                entering_ff, entering_in;
   logic                head_follows_ff, head_follows_in;
   logic                press_pending_ff, press_pending_in;
   logic [7:0]          since_press_ff, since_press_in;
   logic [15:0]         since_frame_ff, since_frame_in;
   lmc_pkg::colour_type held_ff, held_in;
   lmc_pkg::colour_type main_ff, main_in;
   lmc_pkg::colour_type head_ff, head_in;
   lmc_pkg::colour_type colour;
   lmc_pkg::duty_type   grey;

   // Apply a colour to the main strip, and to the head while it follows
   function automatic void show_colour(input lmc_pkg::colour_type c, input logic follows,
                                       inout lmc_pkg::colour_type main_c,
                                       inout lmc_pkg::colour_type head_c);
      main_c = c;
      if (follows) begin
         head_c = c;
      end
   endfunction

   always_comb begin
      mode_in          = mode_ff;
      entering_in      = entering_ff;
      head_follows_in  = head_follows_ff;
      press_pending_in = press_pending_ff;
      held_in          = held_ff;
      main_in          = main_ff;
      head_in          = head_ff;
      colour           = '0;
      grey             = lmc_pkg::knob_grey(item.knob_sample[lmc_pkg::KNOB_BITS-1:0]);

      // Saturating tick counters
      since_press_in = (since_press_ff == lmc_pkg::SINCE_PRESS_MAX) ? since_press_ff
                                                                    : since_press_ff + 8'd1;
      since_frame_in = (since_frame_ff == lmc_pkg::SINCE_FRAME_MAX) ? since_frame_ff
                                                                    : since_frame_ff + 16'd1;

      // Debounce: accept the edge only after the minimum interval
      if (item.button_edge && (since_press_in > cfg.debounce_ticks)) begin
         press_pending_in = 1'b1;
         since_press_in   = '0;
      end

      case (mode_ff)
         lmc_pkg::MODE_ON: begin
            entering_in = 1'b0;
            if (!item.head_switch_on) begin
               mode_in     = lmc_pkg::MODE_OFF;
               entering_in = 1'b1;
            end
            if (item.knob_switch_on) begin
               mode_in     = lmc_pkg::MODE_KNOB;
               entering_in = 1'b1;
            end
            if (press_pending_in) begin
               press_pending_in = 1'b0;
               head_follows_in  = !head_follows_ff;
               if (head_follows_ff) begin
                  head_in = lmc_pkg::ORANGE;
               end
            end
            if (item.frame_valid) begin
               since_frame_in = '0;
               if (item.frame_first == cfg.start_marker) begin
                  held_in = lmc_pkg::rgb(lmc_pkg::DUTY_BITS'(item.frame_red),
                                         lmc_pkg::DUTY_BITS'(item.frame_green),
                                         lmc_pkg::DUTY_BITS'(item.frame_blue));
               end
            end
            colour = (since_frame_in > cfg.silence_ticks) ? '0 : held_in;
            show_colour(colour, head_follows_in, main_in, head_in);
         end
         lmc_pkg::MODE_OFF: begin
            if (entering_ff) begin
               main_in     = '0;
               head_in     = '0;
               entering_in = 1'b0;
            end
            if (item.head_switch_on) begin
               mode_in     = lmc_pkg::MODE_ON;
               entering_in = 1'b1;
            end
            press_pending_in = 1'b0;   // drop presses while off
         end
         lmc_pkg::MODE_KNOB, lmc_pkg::MODE_ORANGE, lmc_pkg::MODE_VIOLET: begin
            if (mode_ff == lmc_pkg::MODE_KNOB) begin
               entering_in = 1'b0;
            end else if (entering_ff) begin
               show_colour((mode_ff == lmc_pkg::MODE_ORANGE) ? lmc_pkg::ORANGE : lmc_pkg::VIOLET,
                           head_follows_ff, main_in, head_in);
               entering_in = 1'b0;
            end
            if (!item.head_switch_on) begin
               mode_in     = lmc_pkg::MODE_OFF;
               entering_in = 1'b1;
            end
            if (!item.knob_switch_on) begin
               mode_in     = lmc_pkg::MODE_ON;
               entering_in = 1'b1;
            end
            if (press_pending_in) begin
               press_pending_in = 1'b0;
               entering_in      = 1'b1;
               case (mode_ff)
                  lmc_pkg::MODE_KNOB:   mode_in = lmc_pkg::MODE_ORANGE;
                  lmc_pkg::MODE_ORANGE: mode_in = lmc_pkg::MODE_VIOLET;
                  default:              mode_in = lmc_pkg::MODE_KNOB;
               endcase
            end
            if (mode_ff == lmc_pkg::MODE_KNOB) begin
               show_colour(lmc_pkg::rgb(grey, grey, grey), head_follows_ff, main_in, head_in);
            end
         end
         default: begin
            mode_in     = lmc_pkg::MODE_ON;
            entering_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff          <= lmc_pkg::MODE_ON;
         entering_ff      <= 1'b1;
         head_follows_ff  <= 1'b0;
         press_pending_ff <= 1'b0;
         since_press_ff   <= '0;
         since_frame_ff   <= '0;
         held_ff          <= '0;
         main_ff          <= '0;
         head_ff          <= '0;
      end else if (step) begin
         mode_ff          <= mode_in;
         entering_ff      <= entering_in;
         head_follows_ff  <= head_follows_in;
         press_pending_ff <= press_pending_in;
         since_press_ff   <= since_press_in;
         since_frame_ff   <= since_frame_in;
         held_ff          <= held_in;
         main_ff          <= main_in;
         head_ff          <= head_in;
      end
   end

   always_comb begin
      result.pad        = '0;
      result.mode_now   = lmc_pkg::mode_code(mode_in);
      result.main_red   = 8'(lmc_pkg::chan(main_in, 2));
      result.main_green = 8'(lmc_pkg::chan(main_in, 1));
      result.main_blue  = 8'(lmc_pkg::chan(main_in, 0));
      result.head_red   = 8'(lmc_pkg::chan(head_in, 2));
      result.head_green = 8'(lmc_pkg::chan(head_in, 1));
      result.head_blue  = 8'(lmc_pkg::chan(head_in, 0));
   end

endmodule

`default_nettype wire

FILE: rtl/led_lamp_mode_controller_unit.sv
`default_nettype none

// Channel   Direction  Bits  Contents
// req_*     in         48    one millisecond tick: switches, button edge, knob, colour frame
// rsp_*     out        56    main and head duties, mode code
// csr_*     in         16    register write: index 0 debounce, 1 silence, 2 start marker
//
// One tick is accepted per cycle unless the result side stalls; a result is offered
// once its tick has passed the input register, then the mode logic into the result register.
// The mode state advances when a tick moves from the input register to the result register.
// A stalled result holds in its register while the input register still takes one more tick.
// Synchronous reset restores the register defaults and the ON mode; no clearing pass.

module led_lamp_mode_controller_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // head_switch_on, knob_switch_on, button_edge, knob_sample[11:0], frame_valid,
   // frame_first[7:0], frame_red[7:0], frame_green[7:0], frame_blue[7:0]
   input  wire  [lmc_pkg::ITEM_BITS-1:0]       req_tdata,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // main_red, main_green, main_blue, head_red, head_green, head_blue, mode_now[2:0], zero pad
   output logic [lmc_pkg::RESULT_BITS-1:0]     rsp_tdata,
   input  wire                                 csr_wen,
   input  wire  [lmc_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire  [lmc_pkg::CSR_DATA_BITS-1:0]   csr_wdata
);

   lmc_pkg::cfg_type    cfg;
   lmc_pkg::item_type   item_ff;
   logic                item_valid_ff;
   lmc_pkg::result_type result_next;
   lmc_pkg::result_type result_ff;
   logic                result_valid_ff;
   logic                advance;

   lmc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Move the held tick through the mode logic once the result register has room
   assign advance    = item_valid_ff && (!result_valid_ff || rsp_tready);
   assign req_tready = !item_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (req_tready) begin
         item_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         item_ff <= lmc_pkg::item_type'(req_tdata);
      end
   end

   lmc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .cfg    (cfg),
      .result (result_next)
   );

   // Result register: load on advance, drop after the transfer out
   always_ff @(posedge clock) begin
      if (reset) begin
         result_valid_ff <= 1'b0;
      end else if (advance) begin
         result_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         result_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_next;
      end
   end

   assign rsp_tvalid = result_valid_ff;
   assign rsp_tdata  = result_ff;

   // A held tick that cannot advance keeps its contents
   a_item_hold: assert property (@(posedge clock) disable iff (reset)
      item_valid_ff && !advance |=> item_valid_ff && $stable(item_ff))
      else $error("input register lost a stalled tick");

   // Every tick sent through the mode logic shows up as a result
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("advanced tick produced no result");

   // Reported mode code stays within the defined modes
   a_mode_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[lmc_pkg::MODE_LSB +: 3] <= lmc_pkg::MODE_CODE_MAX)
      else $error("mode code out of range");

   // Reset empties both registers
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !item_valid_ff)
      else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

FILE: dv/led_lamp_mode_controller_unit_tb.sv
`default_nettype none

module led_lamp_mode_controller_unit_tb;

   timeunit 1ns;
   timeprecision 1ps;

   import lmc_pkg::*;

   // Fixed lamp colours, red in the top byte
   localparam colour_type LAMP_ORANGE = {8'h50, 8'h80, 8'h00};
   localparam colour_type LAMP_VIOLET = {8'h90, 8'h10, 8'hDD};
   localparam int         MAX_SHOWN   = 10;

   logic                      clock;
   logic                      reset;
   logic                      req_tvalid;
   logic                      req_tready;
   // head_switch_on, knob_switch_on, button_edge, knob_sample[11:0], frame_valid,
   // frame_first[7:0], frame_red[7:0], frame_green[7:0], frame_blue[7:0]
   item_type                  req_tdata;
   logic                      rsp_tvalid;
   logic                      rsp_tready;
   // main_red, main_green, main_blue, head_red, head_green, head_blue, mode_now[2:0], zero pad
   logic [RESULT_BITS-1:0]    rsp_tdata;
   logic                      csr_wen;
   logic [CSR_INDEX_BITS-1:0] csr_index;
   logic [CSR_DATA_BITS-1:0]  csr_wdata;

   led_lamp_mode_controller_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // One directed tick; when hand_typed is set, want replaces the predicted outputs
   typedef struct {
      item_type   tick;
      bit         hand_typed;
      result_type want;
   } lamp_step_row;

   // Lamp state as the block should hold it
   logic [7:0]  cfg_debounce;
   logic [15:0] cfg_silence;
   logic [7:0]  cfg_marker;
   logic [2:0]  mode_q;
   logic        entering_q;
   logic        follows_q;
   logic        pending_q;
   logic [7:0]  since_press_q;
   logic [15:0] since_frame_q;
   colour_type  held_q;
   colour_type  main_q;
   colour_type  head_q;

   result_type   lamp_outputs_due[$];
   lamp_step_row directed_ticks[$];
   int           fails;
   bit           send_calm;
   bit           sink_calm;
   bit           head_lvl;
   bit           knob_lvl;

   // Clock: 4 ns period
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run
   initial begin
      #2ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------

   // Put a colour on the main strip; the head copies it while following
   function automatic void show_colour(input colour_type c);
      main_q = c;
      if (follows_q) begin
         head_q = c;
      end
   endfunction

   // Leave a manual mode on a switch; the knob switch is tested last and wins
   function automatic void leave_manual(input item_type t);
      if (!t.head_switch_on) begin
         mode_q     = MODE_CODE_OFF;
         entering_q = 1'b1;
      end
      if (!t.knob_switch_on) begin
         mode_q     = MODE_CODE_ON;
         entering_q = 1'b1;
      end
   endfunction

   // Step to the next manual mode on a pending press; runs after the switch tests
   function automatic void step_on_press(input logic [2:0] next_mode);
      if (pending_q) begin
         pending_q  = 1'b0;
         mode_q     = next_mode;
         entering_q = 1'b1;
      end
   endfunction

   // Advance the lamp state by one tick and return the outputs after it
   function automatic result_type lamp_after_tick(input item_type t);
      result_type r;
      colour_type shade;
      duty_type   grey;
      if (since_press_q != SINCE_PRESS_MAX) begin
         since_press_q++;
      end
      if (since_frame_q != SINCE_FRAME_MAX) begin
         since_frame_q++;
      end
      if (t.button_edge && since_press_q > cfg_debounce) begin
         pending_q     = 1'b1;
         since_press_q = '0;
      end
      case (mode_q)
         MODE_CODE_ON: begin
            entering_q = 1'b0;
            if (!t.head_switch_on) begin
               mode_q     = MODE_CODE_OFF;
               entering_q = 1'b1;
            end
            if (t.knob_switch_on) begin
               mode_q     = MODE_CODE_KNOB;
               entering_q = 1'b1;
            end
            if (pending_q) begin
               pending_q = 1'b0;
               follows_q = !follows_q;
               if (!follows_q) begin
                  head_q = LAMP_ORANGE;
               end
            end
            if (t.frame_valid) begin
               since_frame_q = '0;
               if (t.frame_first == cfg_marker) begin
                  held_q = {t.frame_red, t.frame_green, t.frame_blue};
               end
            end
            // Silent too long: dark main strip (and head while following), held colour kept for later
            shade = (since_frame_q > cfg_silence) ? '0 : held_q;
            show_colour(shade);
         end
         MODE_CODE_OFF: begin
            if (entering_q) begin
               main_q     = '0;
               head_q     = '0;
               entering_q = 1'b0;
            end
            if (t.head_switch_on) begin
               mode_q     = MODE_CODE_ON;
               entering_q = 1'b1;
            end
            pending_q = 1'b0;
         end
         MODE_CODE_KNOB: begin
            entering_q = 1'b0;
            leave_manual(t);
            step_on_press(MODE_CODE_ORANGE);
            // Keep the top DUTY_BITS of the knob reading
            grey = t.knob_sample[KNOB_BITS-1 -: DUTY_BITS];
            show_colour({grey, grey, grey});
         end
         MODE_CODE_ORANGE: begin
            if (entering_q) begin
               show_colour(LAMP_ORANGE);
               entering_q = 1'b0;
            end
            leave_manual(t);
            step_on_press(MODE_CODE_VIOLET);
         end
         MODE_CODE_VIOLET: begin
            if (entering_q) begin
               show_colour(LAMP_VIOLET);
               entering_q = 1'b0;
            end
            leave_manual(t);
            step_on_press(MODE_CODE_KNOB);
         end
         default: begin
            mode_q     = MODE_CODE_ON;
            entering_q = 1'b1;
         end
      endcase
      r            = '0;
      r.main_red   = main_q[23:16];
      r.main_green = main_q[15:8];
      r.main_blue  = main_q[7:0];
      r.head_red   = head_q[23:16];
      r.head_green = head_q[15:8];
      r.head_blue  = head_q[7:0];
      r.mode_now   = mode_q;
      return r;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic item_type make_tick(input bit hs, input bit ks, input bit btn,
                                          input logic [11:0] knob, input bit fv,
                                          input logic [7:0] lead, input logic [7:0] red,
                                          input logic [7:0] green, input logic [7:0] blue);
      item_type t;
      t.head_switch_on = hs;
      t.knob_switch_on = ks;
      t.button_edge    = btn;
      t.knob_sample    = knob;
      t.frame_valid    = fv;
      t.frame_first    = lead;
      t.frame_red      = red;
      t.frame_green    = green;
      t.frame_blue     = blue;
      return t;
   endfunction

   function automatic result_type lamp_out(input colour_type main_c, input colour_type head_c,
                                           input logic [2:0] mode);
      result_type r;
      r          = '0;
      r.main_red = main_c[23:16];
      r.main_green = main_c[15:8];
      r.main_blue  = main_c[7:0];
      r.head_red   = head_c[23:16];
      r.head_green = head_c[15:8];
      r.head_blue  = head_c[7:0];
      r.mode_now   = mode;
      return r;
   endfunction

   function automatic void add_row(input item_type t, input bit typed, input result_type w);
      lamp_step_row row;
      row.tick       = t;
      row.hand_typed = typed;
      row.want       = w;
      directed_ticks.push_back(row);
   endfunction

   // Gap or stall length: long runs of zero, otherwise a random draw that is zero more than half the time
   function automatic int idle_draw(input bit calm);
      if (calm || $urandom_range(0, 1) == 0) begin
         return 0;
      end
      return $urandom_range(0, 17);
   endfunction

   // Offer one tick, wait for its transfer, then book the expected outputs.
   // Called right after a rising edge; tvalid is only lowered when a gap follows.
   task automatic push_tick(input item_type t, input bit typed, input result_type w);
      int         gap;
      result_type predicted;
      if ($urandom_range(0, 63) == 0) begin
         send_calm = !send_calm;
      end
      gap = idle_draw(send_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= t;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = lamp_after_tick(t);
      lamp_outputs_due.push_back(typed ? w : predicted);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] value);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wen <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_DEBOUNCE_TICKS: cfg_debounce = value[7:0];
         CSR_SILENCE_TICKS:  cfg_silence  = value;
         CSR_START_MARKER:   cfg_marker   = value[7:0];
         default: ;
      endcase
   endtask

   // Hold the sender until every booked result is back, then load new register values
   task automatic settle_and_configure(input logic [7:0] debounce, input logic [15:0] silence,
                                       input logic [7:0] marker);
      req_tvalid <= 1'b0;
      while (lamp_outputs_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      write_csr(CSR_DEBOUNCE_TICKS, {8'h00, debounce});
      write_csr(CSR_SILENCE_TICKS, silence);
      write_csr(CSR_START_MARKER, {8'h00, marker});
   endtask

   // Mostly well-formed traffic: sticky switches, frames that usually carry the
   // marker, presses often enough to cycle modes; a few ticks are pure noise.
   task automatic random_ticks(input int count, input int frame_pct);
      item_type   t;
      result_type none;
      none = '0;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 99) < 4) begin
            head_lvl = !head_lvl;
         end
         if ($urandom_range(0, 99) < 5) begin
            knob_lvl = !knob_lvl;
         end
         t.head_switch_on = head_lvl;
         t.knob_switch_on = knob_lvl;
         t.button_edge    = ($urandom_range(0, 99) < 20);
         t.knob_sample    = 12'($urandom_range(0, 4095));
         t.frame_valid    = ($urandom_range(0, 99) < frame_pct);
         t.frame_first    = ($urandom_range(0, 3) != 0) ? cfg_marker
                                                        : 8'($urandom_range(0, 255));
         t.frame_red      = 8'($urandom_range(0, 255));
         t.frame_green    = 8'($urandom_range(0, 255));
         t.frame_blue     = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < 5) begin
            t = item_type'(ITEM_BITS'({$urandom(), $urandom()}));
         end
         push_tick(t, 1'b0, none);
      end
   endtask

   // ---------------------------------------------------------------------------
   // Result side: random stalls, compare each transfer with the oldest booking
   // ---------------------------------------------------------------------------

   initial begin
      result_type got;
      result_type want;
      int         stall;
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if ($urandom_range(0, 63) == 0) begin
            sink_calm = !sink_calm;
         end
         stall = idle_draw(sink_calm);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got = result_type'(rsp_tdata);
         if (lamp_outputs_due.size() == 0) begin
            fails++;
            if (fails <= MAX_SHOWN) begin
               $display("%0t: result with nothing booked: %h", $realtime, got);
            end
         end else begin
            want = lamp_outputs_due.pop_front();
            if (got.main_red !== want.main_red || got.main_green !== want.main_green ||
                got.main_blue !== want.main_blue || got.head_red !== want.head_red ||
                got.head_green !== want.head_green || got.head_blue !== want.head_blue ||
                got.mode_now !== want.mode_now) begin
               fails++;
               if (fails <= MAX_SHOWN) begin
                  $display({"%0t: main exp %h%h%h got %h%h%h, ",
                            "head exp %h%h%h got %h%h%h, mode exp %0d got %0d"},
                           $realtime, want.main_red, want.main_green, want.main_blue,
                           got.main_red, got.main_green, got.main_blue,
                           want.head_red, want.head_green, want.head_blue,
                           got.head_red, got.head_green, got.head_blue,
                           want.mode_now, got.mode_now);
               end
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------

   initial begin
      result_type none;
      none       = '0;
      fails      = 0;
      send_calm  = 1'b0;
      sink_calm  = 1'b0;
      head_lvl   = 1'b1;
      knob_lvl   = 1'b0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wen    = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;

      // Register defaults and power-up lamp state
      cfg_debounce  = DEBOUNCE_RESET;
      cfg_silence   = SILENCE_RESET;
      cfg_marker    = MARKER_RESET;
      mode_q        = MODE_CODE_ON;
      entering_q    = 1'b1;
      follows_q     = 1'b0;
      pending_q     = 1'b0;
      since_press_q = '0;
      since_frame_q = '0;
      held_q        = '0;
      main_q        = '0;
      head_q        = '0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed walk: no debounce, short silence, a marker that is not the default
      settle_and_configure(8'd0, 16'd3, 8'hA5);

      // Power-up: ON, nothing received yet
      add_row(make_tick(1, 0, 0, 12'h000, 0, 8'h00, 8'h00, 8'h00, 8'h00), 1,
              lamp_out('0, '0, MODE_CODE_ON));
      // Good frame shows on the main strip only
      add_row(make_tick(1, 0, 0, 12'h000, 1, 8'hA5, 8'h12, 8'h34, 8'h56), 1,
              lamp_out(24'h123456, '0, MODE_CODE_ON));
      // Press in ON: head starts following
      add_row(make_tick(1, 0, 1, 12'h000, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, none);
      // Wrong first byte: restarts the silence count, colour held
      add_row(make_tick(1, 0, 0, 12'h000, 1, 8'h00, 8'hFF, 8'hFF, 8'hFF), 0, none);
      // Run out the silence window: the last of these goes dark
      for (int k = 0; k < 4; k++) begin
         add_row(make_tick(1, 0, 0, 12'h000, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, none);
      end
      // Full-scale frame lights both again
      add_row(make_tick(1, 0, 0, 12'h000, 1, 8'hA5, 8'hFF, 8'hFF, 8'hFF), 0, none);
      // Press again: head stops following and drops to orange
      add_row(make_tick(1, 0, 1, 12'h000, 0, 8'h00, 8'h00, 8'h00, 8'h00), 1,
              lamp_out(24'hFFFFFF, LAMP_ORANGE, MODE_CODE_ON));
      // Knob switch on: over to KNOB
      add_row(make_tick(1, 1, 0, 12'hFFF, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, none);
      // Knob at full scale; a frame outside ON is dropped
      add_row(make_tick(1, 1, 0, 12'hFFF, 1, 8'hA5, 8'h00, 8'h00, 8'h00), 1,
              lamp_out(24'hFFFFFF, LAMP_ORANGE, MODE_CODE_KNOB));
      // Knob at zero
      add_row(make_tick(1, 1, 0, 12'h000, 0, 8'h00, 8'h00, 8'h00, 8'h00), 1,
              lamp_out('0, LAMP_ORANGE, MODE_CODE_KNOB));
      // Step through ORANGE, VIOLET and back to KNOB
      add_row(make_tick(1, 1, 1, 12'h800, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, none);
      add_row(make_tick(1, 1, 0, 12'h800, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, none);
      add_row(make_tick(1, 1, 1, 12'h800, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, none);
      add_row(make_tick(1, 1, 0, 12'h800, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, none);
      add_row(make_tick(1, 1, 1, 12'h800, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, none);
      // Head switch off in KNOB goes to OFF
      add_row(make_tick(0, 1, 0, 12'h123, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, none);
      // OFF clears both duties on entry
      add_row(make_tick(0, 1, 0, 12'h123, 0, 8'h00, 8'h00, 8'h00, 8'h00), 1,
              lamp_out('0, '0, MODE_CODE_OFF));
      // Press in OFF is dropped; head switch on returns to ON
      add_row(make_tick(1, 0, 1, 12'h000, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, none);
      // Both switches low in ON
      add_row(make_tick(0, 0, 0, 12'h000, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, none);
      add_row(make_tick(1, 0, 0, 12'h000, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, none);
      // Knob switch high with head switch low in ON: knob wins
      add_row(make_tick(0, 1, 0, 12'h000, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, none);
      // Knob switch low plus a press in KNOB: the press wins
      add_row(make_tick(1, 0, 1, 12'h000, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, none);
      add_row(make_tick(1, 1, 0, 12'h000, 0, 8'h00, 8'h00, 8'h00, 8'h00), 0, none);

      foreach (directed_ticks[i]) begin
         push_tick(directed_ticks[i].tick, directed_ticks[i].hand_typed, directed_ticks[i].want);
      end

      // Random phases; each pause drains the block before the registers change
      settle_and_configure(8'($urandom_range(0, 6)), 16'($urandom_range(2, 40)),
                           8'($urandom_range(0, 255)));
      random_ticks(450, 35);
      // Extremes: presses never pass, silence never trips
      settle_and_configure(8'hFF, 16'hFFFF, 8'h00);
      random_ticks(300, 35);
      // Extremes: every press passes, silence trips on every tick without a frame
      settle_and_configure(8'h00, 16'h0000, 8'hFF);
      random_ticks(400, 50);
      settle_and_configure(8'($urandom_range(10, 60)), 16'($urandom_range(20, 300)),
                           8'($urandom_range(0, 255)));
      random_ticks(700, 20);

      // Drain and let the pipeline run dry
      req_tvalid <= 1'b0;
      while (lamp_outputs_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fails == 0 && lamp_outputs_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: led_lamp_mode_controller_unit.f
rtl/lmc_pkg.sv
rtl/lmc_csr.sv
rtl/lmc_core.sv
rtl/led_lamp_mode_controller_unit.sv
dv/led_lamp_mode_controller_unit_tb.sv
